>>> hdl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and codes for the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int unsigned FIELD_CYL_W = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PENDING_W   = 5;
  localparam int unsigned TOTAL_W     = 32;

  // Head cylinder after reset
  localparam logic [FIELD_CYL_W-1:0] START_RESET = FIELD_CYL_W'(15);

  // Item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic                   kind;
    logic [FIELD_CYL_W-1:0] cylinder;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [FIELD_CYL_W-1:0] served_cylinder;
    logic [FIELD_CYL_W-1:0] seek_distance;
    logic [TOTAL_W-1:0]     total_distance;
    logic [PENDING_W-1:0]   pending;
  } out_word_t;

  // Control from the sequencer to the nearest-entry scan unit
  typedef struct packed {
    logic clear;        // start a new search
    logic step;         // an entry is presented this cycle
    logic entry_valid;  // that entry holds a pending request
  } scan_ctl_t;

endpackage

>>> hdl/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-time-first scheduler over a table of pending cylinders.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | word
//   --------+------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_word  | kind, cylinder
//   result  | out_valid, out_stall, out_word | status, served cylinder,
//           |                              | seek, total, pending
//   config  | cfg_wr_en, cfg_wr_data       | start_position
//
// An add walks the valid bits from slot 0 one slot per cycle and stops at the
// first free slot, or reports the table full after the last slot. A serve reads
// every slot through the single read port of the slot table, one per cycle,
// feeding the shared distance unit. One word is in flight at a time; a finished
// result waits in the output register while the next word is accepted. Reset is
// synchronous and clears the valid bits at once, so no clearing pass is run.
// A stalled output holds its word; the sequencer waits until it drains.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler #(
  parameter int unsigned SLOTS         = 16,
  parameter int unsigned CYLINDER_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sstf_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sstf_pkg::out_word_t                  out_word,
  input  logic                                 cfg_wr_en,
  input  logic [sstf_pkg::FIELD_CYL_W-1:0]     cfg_wr_data
);
  import sstf_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned CW    = CYLINDER_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a word
  localparam logic [2:0] S_ADD   = 3'd1;  // look for the lowest free slot
  localparam logic [2:0] S_READ  = 3'd2;  // issue slot reads for a serve
  localparam logic [2:0] S_DRAIN = 3'd3;  // last read data enters the scan
  localparam logic [2:0] S_FIN   = 3'd4;  // commit the chosen slot
  localparam logic [2:0] S_PUSH  = 3'd5;  // hand the result to the output

  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               kind_r, kind_nxt;
  logic [CW-1:0]      cyl_r, cyl_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      start_r, start_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  out_word_t          res_r, res_nxt;
  out_word_t          out_word_r, out_word_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Read pipeline alignment with the registered slot table
  logic               rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               rd_ok_r, rd_ok_nxt;

  logic               mem_wr_en;
  logic [CW-1:0]      mem_rd_data;
  scan_ctl_t          scan_ctl;
  logic               scan_found;
  logic [IDX_W-1:0]   scan_idx;
  logic [CW-1:0]      scan_cyl;
  logic [CW-1:0]      scan_dist;
  logic [TOTAL_W:0]   total_sum;
  logic               in_take;
  logic               out_free;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  sstf_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (CW)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (cyl_r),
    .rd_addr (idx_r),
    .rd_data (mem_rd_data)
  );

  sstf_scan_unit #(
    .IDX_W (IDX_W),
    .CYL_W (CW)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .head      (head_r),
    .entry_cyl (mem_rd_data),
    .entry_idx (rd_idx_r),
    .found     (scan_found),
    .best_idx  (scan_idx),
    .best_cyl  (scan_cyl),
    .best_dist (scan_dist)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    cyl_nxt       = cyl_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    start_nxt     = start_r;
    total_nxt     = total_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    mem_wr_en     = 1'b0;

    rd_pend_nxt = (state_r == S_READ);
    rd_idx_nxt  = idx_r;
    rd_ok_nxt   = valid_r[idx_r];

    scan_ctl.clear       = in_take;
    scan_ctl.step        = rd_pend_r;
    scan_ctl.entry_valid = rd_ok_r;

    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(scan_dist);

    // drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // register write: start position also moves the head
    if (cfg_wr_en) begin
      start_nxt = CW'(cfg_wr_data);
      head_nxt  = CW'(cfg_wr_data);
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          kind_nxt  = in_word.kind;
          cyl_nxt   = CW'(in_word.cylinder);
          idx_nxt   = '0;
          state_nxt = (in_word.kind == KIND_ADD) ? S_ADD : S_READ;
        end
      end
      S_ADD: begin
        res_nxt = '0;
        if (!valid_r[idx_r]) begin
          mem_wr_en          = 1'b1;
          valid_nxt[idx_r]   = 1'b1;
          cnt_nxt            = cnt_r + CNT_W'(1);
          res_nxt.status     = ST_ADDED;
          res_nxt.pending    = PENDING_W'(cnt_r + CNT_W'(1));
          res_nxt.total_distance = total_r;
          state_nxt          = S_PUSH;
        end else if (idx_r == LAST_IDX) begin
          res_nxt.status     = ST_FULL;
          res_nxt.pending    = PENDING_W'(cnt_r);
          res_nxt.total_distance = total_r;
          state_nxt          = S_PUSH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_READ: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_nxt = '0;
        if (scan_found) begin
          // free the slot, move the head, accumulate with saturation
          valid_nxt[scan_idx] = 1'b0;
          cnt_nxt   = cnt_r - CNT_W'(1);
          head_nxt  = scan_cyl;
          total_nxt = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          res_nxt.status          = ST_SERVED;
          res_nxt.served_cylinder = FIELD_CYL_W'(scan_cyl);
          res_nxt.seek_distance   = FIELD_CYL_W'(scan_dist);
          res_nxt.total_distance  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          res_nxt.pending         = PENDING_W'(cnt_r - CNT_W'(1));
        end else begin
          res_nxt.status         = ST_EMPTY;
          res_nxt.total_distance = total_r;
          res_nxt.pending        = PENDING_W'(cnt_r);
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // wait for room in the output register
        if (out_free) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      start_r     <= CW'(START_RESET);
      head_r      <= CW'(START_RESET);
      total_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    kind_r     <= kind_nxt;
    cyl_r      <= cyl_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
  end

  // kind_r and start_r are kept for visibility of the word in flight and the
  // programmed start position; they do not steer the datapath after dispatch
  logic unused_ok;
  assign unused_ok = kind_r ^ (^start_r);

  assign in_stall  = (state_r != S_IDLE) || unused_ok && 1'b0;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> hdl/sstf_slot_mem.sv
// ----------------------------------------------------------------------------
// sstf_slot_mem
// Slot cylinder table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sstf_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sstf_scan_unit.sv
// ----------------------------------------------------------------------------
// sstf_scan_unit
// Shared distance and compare unit: tracks the pending entry nearest the head.
// ----------------------------------------------------------------------------
module sstf_scan_unit #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CYL_W = 10
) (
  input  logic                     clk,
  input  sstf_pkg::scan_ctl_t      ctl,
  input  logic [CYL_W-1:0]         head,
  input  logic [CYL_W-1:0]         entry_cyl,
  input  logic [IDX_W-1:0]         entry_idx,
  output logic                     found,
  output logic [IDX_W-1:0]         best_idx,
  output logic [CYL_W-1:0]         best_cyl,
  output logic [CYL_W-1:0]         best_dist
);
  import sstf_pkg::*;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [CYL_W-1:0] best_cyl_r, best_cyl_nxt;
  logic [CYL_W-1:0] best_dist_r, best_dist_nxt;
  logic [CYL_W-1:0] gap;
  logic             take;

  always_comb begin
    gap = (entry_cyl >= head) ? (entry_cyl - head) : (head - entry_cyl);
    // strict compare: on a tie the earlier (lower) slot stays
    take = ctl.step && ctl.entry_valid && (!found_r || (gap < best_dist_r));

    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_cyl_nxt  = best_cyl_r;
    best_dist_nxt = best_dist_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = entry_idx;
      best_cyl_nxt  = entry_cyl;
      best_dist_nxt = gap;
    end
  end

  always_ff @(posedge clk) begin
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cyl_r  <= best_cyl_nxt;
    best_dist_r <= best_dist_nxt;
  end

  assign found     = found_r;
  assign best_idx  = best_idx_r;
  assign best_cyl  = best_cyl_r;
  assign best_dist = best_dist_r;

endmodule
